@@ hw/rtl/duer_pkg.sv @@
// Shared types and constants of the dual ultrasonic echo ranger.
// No dependencies; every other file of the block depends on this package.
`timescale 1ns / 1ps
`default_nettype none

package duer_pkg;

  localparam int NUM_PAIRS = 5;

  localparam int PAIR_W  = 3;
  localparam int TICK_W  = 16;
  localparam int TRIG_W  = 8;
  localparam int SCALE_W = 12;
  localparam int DIST_W  = 20;
  localparam int SCAN_W  = 22;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [PAIR_W:0]    NUM_PAIRS_CNT = (PAIR_W + 1)'(NUM_PAIRS);
  localparam logic [SCAN_W-1:0]  SCAN_MAX      = {SCAN_W{1'b1}};
  localparam logic [TICK_W-1:0]  TICK_MAX      = {TICK_W{1'b1}};

  localparam logic [TICK_W-1:0]  TIMEOUT_RST = 16'd30000;
  localparam logic [TRIG_W-1:0]  TRIGGER_RST = 8'd5;
  localparam logic [SCALE_W-1:0] SCALE_RST   = 12'd1124;

  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE   = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_TRIG   = 2'd1,
    PH_LISTEN = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DISC    = 2'd1,
    ST_TIMEOUT = 2'd2
  } status_t;

  // sequencer to echo lanes
  typedef struct packed {
    logic              load;    // first stage advances
    logic              step;    // accepted tick inside a scan
    logic              close;   // pair closes on this tick
    logic              sample;  // echo lines are sampled on this tick
    logic [TICK_W-1:0] t;       // tick count of the pair at this tick
  } lane_ctl_t;

  // per-tick fields produced by the sequencer, held in the first stage
  typedef struct packed {
    logic              trigger_level;
    logic [PAIR_W-1:0] trigger_index;
    logic              result_valid;
    logic [PAIR_W-1:0] pair_index;
    logic              scan_done;
    logic [SCAN_W-1:0] scan_ticks;
  } seq_res_t;

endpackage

`default_nettype wire

@@ hw/rtl/duer_if.sv @@
// Handshake channels of the echo ranger: the tick input and the result output.
// Depends on duer_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface duer_tick_if;
  logic valid;
  logic ready;
  logic start_scan;
  logic echo_a;
  logic echo_b;

  modport source (output valid, output start_scan, output echo_a, output echo_b,
                  input ready);
  modport sink (input valid, input start_scan, input echo_a, input echo_b,
                output ready);
endinterface

interface duer_result_if;
  logic                           valid;
  logic                           ready;
  logic                           trigger_level;
  logic [duer_pkg::PAIR_W-1:0]    trigger_index;
  logic                           result_valid;
  logic [duer_pkg::PAIR_W-1:0]    pair_index;
  logic [duer_pkg::TICK_W-1:0]    width_a;
  logic [duer_pkg::TICK_W-1:0]    width_b;
  logic [duer_pkg::DIST_W-1:0]    distance_a;
  logic [duer_pkg::DIST_W-1:0]    distance_b;
  logic [1:0]                     status_a;
  logic [1:0]                     status_b;
  logic                           scan_done;
  logic [duer_pkg::SCAN_W-1:0]    scan_ticks;

  modport source (output valid, output trigger_level, output trigger_index,
                  output result_valid, output pair_index, output width_a,
                  output width_b, output distance_a, output distance_b,
                  output status_a, output status_b, output scan_done,
                  output scan_ticks, input ready);
  modport sink (input valid, input trigger_level, input trigger_index,
                input result_valid, input pair_index, input width_a,
                input width_b, input distance_a, input distance_b,
                input status_a, input status_b, input scan_done,
                input scan_ticks, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/duer_lane.sv @@
// One echo channel: edge capture, width and status at pair close, distance.
// Depends on duer_pkg.
`timescale 1ns / 1ps
`default_nettype none

module duer_lane (
  input  logic                         clk,
  input  logic                         rst,
  input  duer_pkg::lane_ctl_t          ctl,
  input  logic                         level,
  input  logic [duer_pkg::TICK_W-1:0]  timeout,
  input  logic [duer_pkg::SCALE_W-1:0] scale,
  output logic [duer_pkg::TICK_W-1:0]  width,
  output duer_pkg::status_t            status,
  output logic [duer_pkg::DIST_W-1:0]  distance
);
  import duer_pkg::*;

  logic              rise_seen;
  logic              fall_seen;
  logic [TICK_W-1:0] rise_time;
  logic [TICK_W-1:0] fall_time;

  logic [TICK_W-1:0]         close_width;
  status_t                   close_status;
  logic [TICK_W+SCALE_W-1:0] product;

  always_comb begin
    close_width  = '0;
    close_status = ST_OK;
    if (ctl.close) begin
      if (!rise_seen) begin
        close_status = ST_DISC;
      end else if (!fall_seen) begin
        close_width  = timeout;
        close_status = ST_TIMEOUT;
      end else begin
        close_width  = fall_time - rise_time;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rise_seen <= 1'b0;
      fall_seen <= 1'b0;
      rise_time <= '0;
      fall_time <= '0;
    end else if (ctl.step) begin
      if (ctl.close) begin
        rise_seen <= 1'b0;
        fall_seen <= 1'b0;
        rise_time <= '0;
        fall_time <= '0;
      end else if (ctl.sample) begin
        // fall only after a rise; a rise only once per pair
        if (!level && rise_seen && !fall_seen) begin
          fall_seen <= 1'b1;
          fall_time <= ctl.t;
        end
        if (level && !rise_seen) begin
          rise_seen <= 1'b1;
          rise_time <= ctl.t;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      width  <= close_width;
      status <= close_status;
    end
  end

  // 16 x 12 bits shifted by 8 is at most 20 bits, so the result never saturates
  assign product  = (TICK_W + SCALE_W)'(width) * (TICK_W + SCALE_W)'(scale);
  assign distance = product[TICK_W+SCALE_W-1:8];

endmodule

`default_nettype wire

@@ hw/rtl/duer_seq.sv @@
// Scan sequencer: phase, pair counter, pair tick count and scan timer.
// Drives the echo lanes and holds the per-tick control fields. Depends on duer_pkg.
`timescale 1ns / 1ps
`default_nettype none

module duer_seq (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load,
  input  logic                         accept,
  input  logic                         start_scan,
  input  logic [duer_pkg::TICK_W-1:0]  timeout,
  input  logic [duer_pkg::TRIG_W-1:0]  trigger,
  output duer_pkg::lane_ctl_t          ctl,
  output duer_pkg::seq_res_t           res
);
  import duer_pkg::*;

  phase_t            phase, phase_next;
  logic [PAIR_W-1:0] pair_counter, pair_counter_next;
  logic [TICK_W-1:0] elapsed_ticks, elapsed_ticks_next;
  logic [SCAN_W-1:0] scan_timer, scan_timer_next;

  logic              idle, active, close, trig, last;
  logic [PAIR_W-1:0] pair_eff;
  logic [TICK_W-1:0] t;
  logic [SCAN_W-1:0] scan_base, scan_inc;
  seq_res_t          res_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      pair_counter  <= '0;
      elapsed_ticks <= '0;
      scan_timer    <= '0;
    end else begin
      phase         <= phase_next;
      pair_counter  <= pair_counter_next;
      elapsed_ticks <= elapsed_ticks_next;
      scan_timer    <= scan_timer_next;
    end
  end

  always_comb begin
    idle      = (phase == PH_IDLE);
    active    = !idle || start_scan;
    // a scan starts from a clean pair and timer
    pair_eff  = idle ? '0 : pair_counter;
    t         = idle ? '0 : elapsed_ticks;
    scan_base = idle ? '0 : scan_timer;
    scan_inc  = (scan_base == SCAN_MAX) ? scan_base : scan_base + 1'b1;
    close     = active && (t >= timeout);
    trig      = active && !close && (t < TICK_W'(trigger));
    last      = ({1'b0, pair_eff} + 1'b1) >= NUM_PAIRS_CNT;

    phase_next         = phase;
    pair_counter_next  = pair_counter;
    elapsed_ticks_next = elapsed_ticks;
    scan_timer_next    = scan_timer;
    if (accept && active) begin
      scan_timer_next = scan_inc;
      if (close) begin
        elapsed_ticks_next = '0;
        if (last) begin
          phase_next        = PH_IDLE;
          pair_counter_next = '0;
        end else begin
          phase_next        = PH_TRIG;
          pair_counter_next = pair_eff + 1'b1;
        end
      end else begin
        phase_next         = trig ? PH_TRIG : PH_LISTEN;
        pair_counter_next  = pair_eff;
        elapsed_ticks_next = (t == TICK_MAX) ? t : t + 1'b1;
      end
    end

    ctl.load   = load;
    ctl.step   = accept && active;
    ctl.close  = close;
    ctl.sample = active && !close && !trig;
    ctl.t      = t;

    res_next.trigger_level = !trig;
    res_next.trigger_index = pair_eff;
    res_next.result_valid  = close;
    res_next.pair_index    = close ? pair_eff : '0;
    res_next.scan_done     = close && last;
    res_next.scan_ticks    = (close && last) ? scan_inc : '0;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/dual_ultrasonic_echo_ranger.sv @@
// Dual ultrasonic echo ranger top level: registers, two echo lanes, merge stage.
// Depends on duer_pkg, duer_if, duer_seq and duer_lane.
//
// Usage: feed one beat on tick per microsecond, carrying start_scan and the
// two echo levels of the pair being served. Every accepted beat yields exactly
// one beat on result: the trigger level and index to drive, and on the tick a
// pair closes its widths, Q8 centimetre distances and statuses (scan_done and
// scan_ticks on the last pair). start_scan is ignored while a scan runs.
// An accepted tick passes the first stage, which updates the sequencer and
// echo capture state, and the second, which holds the width-times-scale
// product in the output register. Throughput is one beat per cycle while
// result is ready. With result stalled the first stage still takes a beat while
// the output register is full; tick.ready drops only when both stages hold.
// Reset (rst, synchronous) returns the block to idle, clears capture state
// and loads the register defaults: timeout 30000, trigger 5, scale 1124.
// cfg_write writes register cfg_index (0 timeout, 1 trigger length,
// 2 distance scale) at once; other indexes are ignored.
`timescale 1ns / 1ps
`default_nettype none

module dual_ultrasonic_echo_ranger (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [duer_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [duer_pkg::CFG_W-1:0]     cfg_data,
  duer_tick_if.sink                      tick,
  duer_result_if.source                  result
);
  import duer_pkg::*;

  logic [TICK_W-1:0]  timeout_ticks;
  logic [TRIG_W-1:0]  trigger_ticks;
  logic [SCALE_W-1:0] distance_scale;

  logic s1_valid;
  logic out_valid;
  logic out_load;
  logic s1_load;
  logic accept;

  lane_ctl_t         ctl;
  seq_res_t          s1_res;
  logic [TICK_W-1:0] width_a, width_b;
  status_t           status_a, status_b;
  logic [DIST_W-1:0] dist_a, dist_b;

  seq_res_t          out_res;
  logic [TICK_W-1:0] out_width_a, out_width_b;
  logic [DIST_W-1:0] out_dist_a, out_dist_b;
  logic [1:0]        out_status_a, out_status_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks  <= TIMEOUT_RST;
      trigger_ticks  <= TRIGGER_RST;
      distance_scale <= SCALE_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_TIMEOUT: timeout_ticks  <= cfg_data;
        CFG_TRIGGER: trigger_ticks  <= cfg_data[TRIG_W-1:0];
        CFG_SCALE:   distance_scale <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_load   = !out_valid || result.ready;
  assign s1_load    = !s1_valid || out_load;
  assign tick.ready = s1_load;
  assign accept     = tick.valid && s1_load;

  duer_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .load       (s1_load),
    .accept     (accept),
    .start_scan (tick.start_scan),
    .timeout    (timeout_ticks),
    .trigger    (trigger_ticks),
    .ctl        (ctl),
    .res        (s1_res)
  );

  duer_lane u_lane_a (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .level    (tick.echo_a),
    .timeout  (timeout_ticks),
    .scale    (distance_scale),
    .width    (width_a),
    .status   (status_a),
    .distance (dist_a)
  );

  duer_lane u_lane_b (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .level    (tick.echo_b),
    .timeout  (timeout_ticks),
    .scale    (distance_scale),
    .width    (width_b),
    .status   (status_b),
    .distance (dist_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid <= tick.valid;
      end
      if (out_load) begin
        out_valid <= s1_valid;
      end
    end
  end

  // merge the sequencer fields with both lanes into the output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res      <= s1_res;
      out_width_a  <= width_a;
      out_width_b  <= width_b;
      out_dist_a   <= dist_a;
      out_dist_b   <= dist_b;
      out_status_a <= 2'(status_a);
      out_status_b <= 2'(status_b);
    end
  end

  assign result.valid         = out_valid;
  assign result.trigger_level = out_res.trigger_level;
  assign result.trigger_index = out_res.trigger_index;
  assign result.result_valid  = out_res.result_valid;
  assign result.pair_index    = out_res.pair_index;
  assign result.width_a       = out_width_a;
  assign result.width_b       = out_width_b;
  assign result.distance_a    = out_dist_a;
  assign result.distance_b    = out_dist_b;
  assign result.status_a      = out_status_a;
  assign result.status_b      = out_status_b;
  assign result.scan_done     = out_res.scan_done;
  assign result.scan_ticks    = out_res.scan_ticks;

  a_hold_first_stage: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !out_load) |=> s1_valid)
    else $error("first stage beat lost while output stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> tick.ready)
    else $error("tick not taken with an empty output register");

  a_done_is_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.scan_done) |-> out_res.result_valid)
    else $error("scan done without a pair result");

  a_disc_is_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status_a == 2'(ST_DISC)) |-> (out_width_a == '0 && out_dist_a == '0))
    else $error("disconnected channel with a non-zero width");

endmodule

`default_nettype wire

@@ bench/dual_ultrasonic_echo_ranger_tb.sv @@
// Self-checking bench for the dual ultrasonic echo ranger: drives one tick beat per
// accepted handshake and checks every result beat against a tick-accurate model.
// Depends on duer_pkg, duer_if and the dual_ultrasonic_echo_ranger top level.
`timescale 1ns / 1ps

module dual_ultrasonic_echo_ranger_tb;
  import duer_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int PRINT_CAP   = 50;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic [DIST_W-1:0]    DIST_SAT  = '1;

  typedef struct packed {
    logic              trigger_level;
    logic [PAIR_W-1:0] trigger_index;
    logic              result_valid;
    logic [PAIR_W-1:0] pair_index;
    logic [TICK_W-1:0] width_a;
    logic [TICK_W-1:0] width_b;
    logic [DIST_W-1:0] distance_a;
    logic [DIST_W-1:0] distance_b;
    status_t           status_a;
    status_t           status_b;
    logic              scan_done;
    logic [SCAN_W-1:0] scan_ticks;
  } ranger_beat_t;

  typedef enum int {ECHO_QUIET, ECHO_PULSE, ECHO_STUCK, ECHO_NOISY} echo_mode_t;

  typedef struct {
    echo_mode_t mode;
    int         rise_at;
    int         fall_at;
  } echo_plan_t;

  class echo_scoreboard;
    ranger_beat_t      want_q[$];
    int                errors;
    int                n_ticks;
    int                n_closes;
    int                n_scans;
    logic [TICK_W-1:0]  timeout_r;
    logic [TRIG_W-1:0]  trig_r;
    logic [SCALE_W-1:0] scale_r;
    phase_t             phase;
    logic [PAIR_W-1:0]  pair;
    logic [TICK_W-1:0]  elapsed;
    logic [SCAN_W-1:0]  scan_timer;
    bit                 rise_seen[2];
    bit                 fall_seen[2];
    logic [TICK_W-1:0]  rise_t[2];
    logic [TICK_W-1:0]  fall_t[2];

    function new();
      timeout_r  = TIMEOUT_RST;
      trig_r     = TRIGGER_RST;
      scale_r    = SCALE_RST;
      phase      = PH_IDLE;
      pair       = '0;
      elapsed    = '0;
      scan_timer = '0;
      clear_echo();
    endfunction

    function void clear_echo();
      for (int c = 0; c < 2; c++) begin
        rise_seen[c] = 0;
        fall_seen[c] = 0;
        rise_t[c]    = '0;
        fall_t[c]    = '0;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_TIMEOUT: timeout_r = val[TICK_W-1:0];
        CFG_TRIGGER: trig_r    = val[TRIG_W-1:0];
        CFG_SCALE:   scale_r   = val[SCALE_W-1:0];
        default: ;
      endcase
    endfunction

    // fall is checked before rise, so a line high on its first sample cannot fall then
    function void take_echo(int c, bit level, logic [TICK_W-1:0] t);
      if (!level && rise_seen[c] && !fall_seen[c]) begin
        fall_seen[c] = 1;
        fall_t[c]    = t;
      end
      if (level && !rise_seen[c]) begin
        rise_seen[c] = 1;
        rise_t[c]    = t;
      end
    endfunction

    function void close_echo(int c, output logic [TICK_W-1:0] w,
                             output logic [DIST_W-1:0] d, output status_t st);
      longint unsigned prod;
      if (!rise_seen[c]) begin
        w  = '0;
        d  = '0;
        st = ST_DISC;
        return;
      end
      if (!fall_seen[c]) begin
        w  = timeout_r;
        st = ST_TIMEOUT;
      end else begin
        w  = fall_t[c] - rise_t[c];
        st = ST_OK;
      end
      prod = (longint'(w) * longint'(scale_r)) >> 8;
      d = (prod > DIST_SAT) ? DIST_SAT : prod[DIST_W-1:0];
    endfunction

    function void note_tick(bit start, bit ea, bit eb);
      ranger_beat_t r;
      logic [TICK_W-1:0] t;
      r = '0;
      r.trigger_level = 1'b1;
      n_ticks++;
      if (phase == PH_IDLE) begin
        if (!start) begin
          want_q.push_back(r);
          return;
        end
        pair       = '0;
        elapsed    = '0;
        scan_timer = '0;
        clear_echo();
        phase = PH_TRIG;
      end
      if (scan_timer < SCAN_MAX) scan_timer++;
      r.trigger_index = pair;
      t = elapsed;
      if (t >= timeout_r) begin
        r.result_valid = 1'b1;
        r.pair_index   = pair;
        close_echo(0, r.width_a, r.distance_a, r.status_a);
        close_echo(1, r.width_b, r.distance_b, r.status_b);
        n_closes++;
        if (int'(pair) + 1 >= NUM_PAIRS || pair >= 3'd7) begin
          r.scan_done  = 1'b1;
          r.scan_ticks = scan_timer;
          phase = PH_IDLE;
          pair  = '0;
          n_scans++;
        end else begin
          pair++;
          phase = PH_TRIG;
        end
        elapsed = '0;
        clear_echo();
        want_q.push_back(r);
        return;
      end
      if (t < trig_r) begin
        r.trigger_level = 1'b0;
        phase = PH_TRIG;
      end else begin
        phase = PH_LISTEN;
        take_echo(0, ea, t);
        take_echo(1, eb, t);
      end
      if (elapsed < TICK_MAX) elapsed++;
      want_q.push_back(r);
    endfunction

    function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= PRINT_CAP)
          $display("%0t mismatch on %s: expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(ranger_beat_t got);
      ranger_beat_t w;
      if (want_q.size() == 0) begin
        errors++;
        if (errors <= PRINT_CAP)
          $display("%0t result beat with nothing expected: expected none, actual %h",
                   $time, got);
        return;
      end
      w = want_q.pop_front();
      cmp_field("trigger_level", w.trigger_level, got.trigger_level);
      cmp_field("trigger_index", w.trigger_index, got.trigger_index);
      cmp_field("result_valid",  w.result_valid,  got.result_valid);
      cmp_field("pair_index",    w.pair_index,    got.pair_index);
      cmp_field("width_a",       w.width_a,       got.width_a);
      cmp_field("width_b",       w.width_b,       got.width_b);
      cmp_field("distance_a",    w.distance_a,    got.distance_a);
      cmp_field("distance_b",    w.distance_b,    got.distance_b);
      cmp_field("status_a",      w.status_a,      got.status_a);
      cmp_field("status_b",      w.status_b,      got.status_b);
      cmp_field("scan_done",     w.scan_done,     got.scan_done);
      cmp_field("scan_ticks",    w.scan_ticks,    got.scan_ticks);
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  duer_tick_if   tick_ch ();
  duer_result_if res_ch ();

  dual_ultrasonic_echo_ranger u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tick      (tick_ch),
    .result    (res_ch)
  );

  echo_scoreboard sb = new();
  echo_plan_t     plan[2];
  bit             idling = 1;
  int             stall_left = 0;
  int             n_writes = 0;
  int             cycles = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side: while idling is set, start random bursts with ready held low
  always @(negedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      res_ch.ready <= 1'b0;
      stall_left--;
    end else if (idling && $urandom_range(0, 7) == 0) begin
      res_ch.ready <= 1'b0;
      stall_left = $urandom_range(0, 6);
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    ranger_beat_t got;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got.trigger_level = res_ch.trigger_level;
      got.trigger_index = res_ch.trigger_index;
      got.result_valid  = res_ch.result_valid;
      got.pair_index    = res_ch.pair_index;
      got.width_a       = res_ch.width_a;
      got.width_b       = res_ch.width_b;
      got.distance_a    = res_ch.distance_a;
      got.distance_b    = res_ch.distance_b;
      got.status_a      = status_t'(res_ch.status_a);
      got.status_b      = status_t'(res_ch.status_b);
      got.scan_done     = res_ch.scan_done;
      got.scan_ticks    = res_ch.scan_ticks;
      sb.check_result(got);
    end
  end

  // entered and left at a falling edge
  task automatic send_tick(bit s, bit a, bit b);
    if (idling && $urandom_range(0, 5) == 0) begin
      tick_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    tick_ch.valid      <= 1'b1;
    tick_ch.start_scan <= s;
    tick_ch.echo_a     <= a;
    tick_ch.echo_b     <= b;
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
    sb.note_tick(s, a, b);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    tick_ch.valid <= 1'b0;
    while (sb.want_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    sb.write_reg(idx, val);
    n_writes++;
    @(negedge clk);
  endtask

  // upper data bits beyond the trigger and scale registers are random and must be dropped
  task automatic set_config(int tmo, int trig, int scale);
    logic [CFG_W-1:0] v;
    write_reg(CFG_TIMEOUT, CFG_W'(tmo));
    v = CFG_W'($urandom);
    v[TRIG_W-1:0] = TRIG_W'(trig);
    write_reg(CFG_TRIGGER, v);
    v = CFG_W'($urandom);
    v[SCALE_W-1:0] = SCALE_W'(scale);
    write_reg(CFG_SCALE, v);
  endtask

  function automatic bit plan_level(int c, int t);
    case (plan[c].mode)
      ECHO_PULSE: return (t >= plan[c].rise_at) && (t < plan[c].fall_at);
      ECHO_STUCK: return t >= plan[c].rise_at;
      ECHO_NOISY: return 1'($urandom_range(0, 1));
      default:    return 1'b0;
    endcase
  endfunction

  function automatic void new_plans();
    int r;
    for (int c = 0; c < 2; c++) begin
      r = $urandom_range(0, 9);
      plan[c].mode    = (r < 2) ? ECHO_QUIET : (r < 7) ? ECHO_PULSE :
                        (r < 9) ? ECHO_STUCK : ECHO_NOISY;
      plan[c].rise_at = $urandom_range(0, int'(sb.timeout_r) + 1);
      plan[c].fall_at = plan[c].rise_at + $urandom_range(1, int'(sb.timeout_r) + 1);
    end
  endfunction

  task automatic drive_plan_tick(bit s, bit noisy);
    bit a;
    bit b;
    if (noisy) begin
      a = 1'($urandom);
      b = 1'($urandom);
    end else begin
      a = plan_level(0, int'(sb.elapsed));
      b = plan_level(1, int'(sb.elapsed));
    end
    send_tick(s, a, b);
  endtask

  initial begin
    bit st;
    rst                = 1'b1;
    cfg_write          = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    tick_ch.valid      = 1'b0;
    tick_ch.start_scan = 1'b0;
    tick_ch.echo_a     = 1'b0;
    tick_ch.echo_b     = 1'b0;
    res_ch.ready       = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // idle ticks, then a scan on reset defaults; starts inside the scan are ignored
    send_tick(0, 0, 0);
    send_tick(0, 1, 1);
    send_tick(1, 0, 0);
    repeat (4) send_tick(1, 1, 0);
    send_tick(0, 1, 0);
    send_tick(0, 1, 1);
    send_tick(0, 0, 1);
    send_tick(0, 0, 1);
    // shorten the timeout mid-scan: pair 0 closes on the next tick
    wait_drained();
    set_config(3, 1, SCALE_RST);
    send_tick(0, 0, 0);
    send_tick(0, 0, 0);
    send_tick(0, 1, 0);
    send_tick(0, 0, 0);
    send_tick(0, 1, 1);
    // no trigger pulse, full scale
    wait_drained();
    set_config(3, 0, 4095);
    send_tick(0, 1, 1);
    send_tick(0, 1, 0);
    send_tick(0, 1, 0);
    send_tick(0, 0, 0);
    // zero timeout closes each remaining pair on its first tick
    wait_drained();
    write_reg(CFG_TIMEOUT, '0);
    write_reg(CFG_SPARE, CFG_W'($urandom));
    send_tick(0, 1, 1);
    send_tick(0, 1, 1);
    send_tick(0, 0, 0);

    // one pair with the longest trigger and full scale: a stuck high, b a short pulse
    wait_drained();
    set_config(300, 255, 4095);
    plan[0] = '{ECHO_STUCK, 280, 0};
    plan[1] = '{ECHO_PULSE, 256, 290};
    drive_plan_tick(1, 0);
    repeat (300) drive_plan_tick(0, 0);

    for (int ph = 0; ph < 8; ph++) begin
      wait_drained();
      idling = (ph != 7);
      case (ph)
        0:       set_config(8, 0, 0);
        1:       set_config(1, 255, 4095);
        2:       set_config(0, $urandom_range(0, 255), $urandom_range(0, 4095));
        3:       set_config(30, 30, $urandom_range(0, 4095));
        default: set_config($urandom_range(2, 30), $urandom_range(0, 6),
                            $urandom_range(0, 4095));
      endcase
      if ($urandom_range(0, 1) == 1) write_reg(CFG_SPARE, CFG_W'($urandom));
      repeat (150) begin
        if (sb.elapsed == '0) new_plans();
        if (sb.phase == PH_IDLE) st = ($urandom_range(0, 2) != 0);
        else                     st = ($urandom_range(0, 3) == 0);
        drive_plan_tick(st, $urandom_range(0, 9) == 0);
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    $display("Run covered %0d ticks, %0d pair closes and %0d finished scans,", sb.n_ticks,
             sb.n_closes, sb.n_scans);
    $display("with %0d register writes from zero to full-scale settings.", n_writes);
    if (sb.errors == 0 && sb.want_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
